/* rtl/core/i2cseq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C transfer sequencer package
// Shared types, codes and field widths for the sequencer core.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned PhaseW    = 2;
  localparam int unsigned AckSetW   = 2;
  localparam int unsigned InDataW   = 48;  // 43 field bits, zero-filled to bytes
  localparam int unsigned OutDataW  = 40;  // 34 field bits, zero-filled to bytes

  localparam logic [ByteW-1:0] AddrWriteMask = 8'hFE;
  localparam logic [ByteW-1:0] AddrReadBit   = 8'h01;

  // Item kind carried on tuser
  localparam logic KindStart = 1'b0;
  localparam logic KindEvent = 1'b1;

  // Acknowledge set-up requests
  localparam logic [AckSetW-1:0] AckKeep = 2'd0;
  localparam logic [AckSetW-1:0] AckOn   = 2'd1;
  localparam logic [AckSetW-1:0] AckOff  = 2'd2;

  // Reported phase codes
  localparam logic [PhaseW-1:0] PhCodeIdle = 2'd0;
  localparam logic [PhaseW-1:0] PhCodeAddr = 2'd1;
  localparam logic [PhaseW-1:0] PhCodeSend = 2'd2;
  localparam logic [PhaseW-1:0] PhCodeRecv = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ADDR = 4'b0010,
    PH_SEND = 4'b0100,
    PH_RECV = 4'b1000
  } phase_e;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] address;
    logic [ByteW-1:0] send_count;
    logic [ByteW-1:0] receive_count;
    logic             ack_detected;
    logic             transmitting;
    logic             stop_detected;
    logic [ByteW-1:0] rx_byte;
    logic [ByteW-1:0] tx_byte;
  } item_t;

  typedef struct packed {
    logic [PhaseW-1:0]  phase;
    logic               start_accepted;
    logic               gen_start;
    logic               gen_stop;
    logic               load_shift;
    logic [ByteW-1:0]   shift_byte;
    logic               wait_release;
    logic [AckSetW-1:0] ack_setup;
    logic               store_rx;
    logic [ByteW-1:0]   rx_data;
    logic [ByteW-1:0]   buffer_index;
  } result_t;

  typedef struct packed {
    phase_e           phase;
    logic [ByteW-1:0] target_addr;
    logic [ByteW-1:0] send_left;
    logic [ByteW-1:0] receive_left;
    logic [ByteW-1:0] send_pos;
    logic [ByteW-1:0] receive_pos;
  } ctx_t;

  function automatic logic [PhaseW-1:0] phase_code(input phase_e ph);
    logic [PhaseW-1:0] code;
    case (ph)
      PH_ADDR: code = PhCodeAddr;
      PH_SEND: code = PhCodeSend;
      PH_RECV: code = PhCodeRecv;
      default: code = PhCodeIdle;
    endcase
    return code;
  endfunction

endpackage

/* rtl/core/i2c_master_transfer_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master transfer sequencer
// Write-then-read transfer control above a byte-level shift unit.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                   Beat rule
//  --------  ---------  ----------------------------------------  ----------------
//  s_axis    in         tuser: kind; tdata: command/event fields  one item per beat
//  m_axis    out        tdata: phase, requests, rx byte, index    one result per item
//
//  Flow: an accepted beat lands in the input register, is stepped through the
//  sequencer logic and is captured in the result register, which drives m_axis.
//  Throughput is one beat per cycle while m_axis_tready is high, set by the
//  context register that each item reads and updates in one pass.
//  Reset: rst_ni clears both stage valids and the context to idle.
//  Stalls: with m_axis_tready low the result register holds; the input register
//  still takes one beat, then s_axis_tready drops until the result moves on.
//
module i2c_master_transfer_sequencer import i2cseq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] address, [15:8] send_count, [23:16] receive_count, [24] ack_detected,
  // [25] transmitting, [26] stop_detected, [34:27] rx_byte, [42:35] tx_byte,
  // [47:43] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] kind
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [1:0] phase, [2] start_accepted, [3] gen_start, [4] gen_stop, [5] load_shift,
  // [13:6] shift_byte, [14] wait_release, [16:15] ack_setup, [17] store_rx,
  // [25:18] rx_data, [33:26] buffer_index, [39:34] zero
  output logic [OutDataW-1:0] m_axis_tdata
);

  // Input stage
  logic  in_vld_q;
  item_t in_q;
  // Result stage
  logic    out_vld_q;
  result_t out_q;

  ctx_t    ctx_q, ctx_d;
  result_t res_d;
  logic    out_free, step_en, in_take;

  // The result register is free when empty or being drained this cycle
  assign out_free      = !out_vld_q || m_axis_tready;
  assign step_en       = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  // Unpack the beat into the input register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.kind          <= s_axis_tuser;
      in_q.address       <= s_axis_tdata[7:0];
      in_q.send_count    <= s_axis_tdata[15:8];
      in_q.receive_count <= s_axis_tdata[23:16];
      in_q.ack_detected  <= s_axis_tdata[24];
      in_q.transmitting  <= s_axis_tdata[25];
      in_q.stop_detected <= s_axis_tdata[26];
      in_q.rx_byte       <= s_axis_tdata[34:27];
      in_q.tx_byte       <= s_axis_tdata[42:35];
    end
  end

  i2cseq_step u_step (
    .ctx_i  (ctx_q),
    .item_i (in_q),
    .ctx_o  (ctx_d),
    .res_o  (res_d)
  );

  // Advance the context only when the item actually moves to the result stage
  i2cseq_ctx u_ctx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_i   (step_en),
    .ctx_d_i (ctx_d),
    .ctx_q_o (ctx_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0,
                          out_q.buffer_index,
                          out_q.rx_data,
                          out_q.store_rx,
                          out_q.ack_setup,
                          out_q.wait_release,
                          out_q.shift_byte,
                          out_q.load_shift,
                          out_q.gen_stop,
                          out_q.gen_start,
                          out_q.start_accepted,
                          out_q.phase};

endmodule

/* rtl/core/i2cseq_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C transfer sequencer step logic
// Next context and result for one item, purely combinational.
// ----------------------------------------------------------------------------
module i2cseq_step import i2cseq_pkg::*; (
  input  ctx_t    ctx_i,
  input  item_t   item_i,
  output ctx_t    ctx_o,
  output result_t res_o
);

  logic do_advance;

  always_comb begin
    ctx_o      = ctx_i;
    res_o      = '0;
    do_advance = 1'b0;

    if (item_i.kind == KindStart) begin
      if (ctx_i.phase == PH_IDLE) begin
        ctx_o.phase          = PH_ADDR;
        ctx_o.target_addr    = item_i.address;
        ctx_o.send_left      = item_i.send_count;
        ctx_o.receive_left   = item_i.receive_count;
        ctx_o.send_pos       = '0;
        ctx_o.receive_pos    = '0;
        res_o.start_accepted = 1'b1;
        res_o.gen_start      = 1'b1;
        res_o.load_shift     = 1'b1;
        res_o.shift_byte     = item_i.address & AddrWriteMask;
      end
    end else begin
      case (ctx_i.phase)
        PH_ADDR: begin
          if (!item_i.ack_detected) begin
            ctx_o.phase = PH_IDLE;
          end else if (item_i.transmitting) begin
            do_advance = 1'b1;
          end else begin
            ctx_o.phase        = PH_RECV;
            res_o.ack_setup    = AckOn;
            res_o.wait_release = 1'b1;
          end
        end
        PH_SEND: begin
          if (!item_i.ack_detected) begin
            ctx_o.phase = PH_IDLE;
          end else begin
            do_advance = 1'b1;
          end
        end
        PH_RECV: begin
          if (item_i.stop_detected) begin
            ctx_o.phase = PH_IDLE;
          end else if (ctx_i.receive_left != '0) begin
            res_o.store_rx     = 1'b1;
            res_o.rx_data      = item_i.rx_byte;
            res_o.buffer_index = ctx_i.receive_pos;
            res_o.wait_release = 1'b1;
            ctx_o.receive_pos  = ctx_i.receive_pos + 8'd1;
            ctx_o.receive_left = ctx_i.receive_left - 8'd1;
            // last byte: drop the ack so the slave sees a nack
            if (ctx_i.receive_left == 8'd1) begin
              res_o.ack_setup = AckOff;
            end
          end else begin
            res_o.gen_stop = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // Send the next byte, or turn to repeated start or stop
    if (do_advance) begin
      if (ctx_i.send_left != '0) begin
        ctx_o.phase        = PH_SEND;
        res_o.load_shift   = 1'b1;
        res_o.shift_byte   = item_i.tx_byte;
        res_o.buffer_index = ctx_i.send_pos;
        ctx_o.send_pos     = ctx_i.send_pos + 8'd1;
        ctx_o.send_left    = ctx_i.send_left - 8'd1;
      end else if (ctx_i.receive_left != '0) begin
        ctx_o.phase      = PH_ADDR;
        res_o.gen_start  = 1'b1;
        res_o.load_shift = 1'b1;
        res_o.shift_byte = ctx_i.target_addr | AddrReadBit;
      end else begin
        ctx_o.phase    = PH_SEND;
        res_o.gen_stop = 1'b1;
      end
    end

    res_o.phase = phase_code(ctx_o.phase);
  end

endmodule

/* rtl/core/i2cseq_ctx.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C transfer sequencer context
// Holds phase, address, counts and buffer positions between items.
// ----------------------------------------------------------------------------
module i2cseq_ctx import i2cseq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic upd_i,
  input  ctx_t ctx_d_i,
  output ctx_t ctx_q_o
);

  ctx_t ctx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_q.phase        <= PH_IDLE;
      ctx_q.target_addr  <= '0;
      ctx_q.send_left    <= '0;
      ctx_q.receive_left <= '0;
      ctx_q.send_pos     <= '0;
      ctx_q.receive_pos  <= '0;
    end else if (upd_i) begin
      ctx_q <= ctx_d_i;
    end
  end

  assign ctx_q_o = ctx_q;

endmodule

/* rtl/core/i2cseq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C transfer sequencer checker
// Port-level properties of the sequencer result stream, bound to the top.
// ----------------------------------------------------------------------------
module i2cseq_checker import i2cseq_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  // A held result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // An accepted start always opens the address phase with start and address load
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[2] |->
      m_axis_tdata[1:0] == PhCodeAddr && m_axis_tdata[3] && m_axis_tdata[5])
    else $error("start accepted without address phase set-up");

  // A stored byte comes only from the receive phase
  a_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[17] |-> m_axis_tdata[1:0] == PhCodeRecv)
    else $error("received byte stored outside receive phase");

  // Unused byte fields read as zero
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[5] || m_axis_tdata[13:6] == '0) &&
                      (m_axis_tdata[17] || m_axis_tdata[25:18] == '0))
    else $error("byte field set without its strobe");

  // Never start and stop together; no undefined ack code
  a_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[4]) &&
                      m_axis_tdata[16:15] != 2'd3)
    else $error("conflicting bus requests");

endmodule

bind i2c_master_transfer_sequencer i2cseq_checker u_i2cseq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
